>>> design/assert_macros.svh
// Assertion macros shared by the tape segment position map RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> design/tsp_pkg.sv
// Shared types and constants for the tape segment position map.
// No dependencies; imported by tsp_seg_size and the top level.
package tsp_pkg;

    localparam int DEF_MAX_SEGMENTS  = 4096;
    localparam int DEF_SEGMENT_BYTES = 32768;
    localparam int DEF_SECTOR_BYTES  = 1024;

    localparam int SEG_IN_W = 12;
    localparam int SEG_W    = 13;
    localparam int OFF_W    = 15;
    localparam int POS_W    = 28;
    localparam int MASK_W   = 32;
    localparam int CFG_W    = 12;
    localparam int KIND_W   = 2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 56;

    // Cursor walks no longer than this are taken from where the cursor stands.
    localparam int NEAR_LIMIT = 10;

    localparam logic REG_FIRST_SEG = 1'b0;
    localparam logic REG_LAST_SEG  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD     = 2'd0,
        KIND_POS2SEG  = 2'd1,
        KIND_SEG2POS  = 2'd2,
        KIND_CAPACITY = 2'd3
    } kind_t;

endpackage

>>> design/tape_segment_position_map_unit.sv
// Tape segment position map, top level: handshake, sequencer and cursor state.
// Depends on tsp_pkg, tsp_ram, tsp_seg_size and assert_macros.svh.
//
// One transaction at a time. A mask load steps through the setup, load and
// result states. A byte-position query, a capacity recompute and a segment
// query inside the data area walk the segment-size RAM one entry per cycle
// over N segments: up to last_data_seg - first_data_seg + 1 for the first
// two, and the distance from the (possibly relocated) cursor for a segment
// query. A segment query outside the data area skips the walk and goes from
// setup straight to the result state. The single read port of the size RAM
// sets the pace of every walk. The table is not cleared after reset; masks
// must be loaded before any query touches them.
`include "assert_macros.svh"

module tape_segment_position_map_unit #(
    parameter int MAX_SEGMENTS  = tsp_pkg::DEF_MAX_SEGMENTS,
    parameter int SEGMENT_BYTES = tsp_pkg::DEF_SEGMENT_BYTES,
    parameter int SECTOR_BYTES  = tsp_pkg::DEF_SECTOR_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [tsp_pkg::CFG_W-1:0]        cfg_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: segment_in[11:0], bad_mask[43:12], byte_pos[71:44]
    input  logic [tsp_pkg::IN_TDATA_W-1:0]   s_tdata,
    // s_tuser: kind[1:0]
    input  logic [tsp_pkg::KIND_W-1:0]       s_tuser,
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: segment_out[12:0], byte_offset[27:13], position_out[55:28]
    output logic [tsp_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import tsp_pkg::*;

    localparam int AW     = $clog2(MAX_SEGMENTS);
    localparam int SIZE_W = $clog2(SEGMENT_BYTES + 1);
    localparam int REM_W  = POS_W + 2;
    localparam int D_W    = SEG_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_LOAD,
        S_WALK,
        S_RESULT
    } state_t;

    // Control state
    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [CFG_W-1:0]       first_reg, first_next;
    logic [CFG_W-1:0]       last_reg, last_next;
    logic [SEG_W-1:0]       cur_seg_reg, cur_seg_next;
    logic [POS_W-1:0]       cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0]       cap_reg, cap_next;

    // Item and walk payload
    kind_t                  kind_reg, kind_next;
    logic [SEG_IN_W-1:0]    seg_in_reg, seg_in_next;
    logic [MASK_W-1:0]      mask_reg, mask_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [SEG_W-1:0]       walk_seg_reg, walk_seg_next;
    logic signed [REM_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0]      last_sz_reg, last_sz_next;
    logic                   fwd_reg, fwd_next;
    logic [SEG_W-1:0]       res_seg_reg, res_seg_next;
    logic [OFF_W-1:0]       res_off_reg, res_off_next;
    logic [POS_W-1:0]       res_pos_reg, res_pos_next;

    // RAM and size unit
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SIZE_W-1:0]      load_size;
    logic                   mem_re;
    logic [SEG_W-1:0]       rd_req_seg;
    logic [31:0]            rd_req_wide;
    logic [31:0]            wr_wide;
    logic [SIZE_W-1:0]      mem_rdata;

    // Walk datapath
    logic                   slot_free;
    logic [SEG_W-1:0]       rd_seg;
    logic                   rd_in_range;
    logic [SIZE_W-1:0]      sz;
    logic signed [REM_W-1:0] sz_s;
    logic signed [REM_W-1:0] off_sum;
    logic [SEG_W-1:0]       last_ext;

    // Segment query setup
    logic signed [D_W-1:0]  seg_s, cur_s, first_s, last_s, near_s;
    logic signed [D_W-1:0]  d1, d2, nd2, d3, d2a, d2f;
    logic                   jump_first, jump_last, fwd_f;
    logic [SEG_W-1:0]       cur_a, cur_f;
    logic [POS_W-1:0]       pos_a, pos_f;

    tsp_ram #(
        .WIDTH(SIZE_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_size_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(load_size),
        .re   (mem_re),
        .raddr(rd_req_wide[AW-1:0]),
        .rdata(mem_rdata)
    );

    // Store the usable size, not the mask: the walks only ever need the size.
    tsp_seg_size #(
        .SEGMENT_BYTES(SEGMENT_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_seg_size (
        .clk (clk),
        .mask(mask_reg),
        .size(load_size)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign slot_free = !out_valid_reg || m_tready;

    assign wr_wide     = 32'(seg_in_reg);
    assign mem_waddr   = wr_wide[AW-1:0];
    assign rd_req_wide = 32'(rd_req_seg);
    assign last_ext    = {1'b0, last_reg};

    // Segment whose size arrives from the RAM in this cycle.
    always_comb
    begin
        unique case (kind_reg)
            KIND_POS2SEG:  rd_seg = walk_seg_reg;
            KIND_SEG2POS:  rd_seg = fwd_reg ? cur_seg_reg : cur_seg_reg - SEG_W'(1);
            KIND_CAPACITY: rd_seg = cur_seg_reg;
            KIND_LOAD:     rd_seg = cur_seg_reg;
        endcase
    end

    // Segments past the table read as size zero.
    assign rd_in_range = 32'(rd_seg) < 32'(MAX_SEGMENTS);
    assign sz          = rd_in_range ? mem_rdata : '0;
    assign sz_s        = $signed(REM_W'(sz));
    assign off_sum     = rem_reg + $signed(REM_W'(last_sz_reg));

    // Pick the walk start for a segment query: jump to the start or the end
    // of the data area when that is closer and the cursor is over NEAR_LIMIT away.
    assign seg_s   = $signed(D_W'(seg_in_reg));
    assign cur_s   = $signed(D_W'(cur_seg_reg));
    assign first_s = $signed(D_W'(first_reg));
    assign last_s  = $signed(D_W'(last_reg));
    assign near_s  = $signed(D_W'(NEAR_LIMIT));
    assign d2      = seg_s - cur_s;
    assign nd2     = cur_s - seg_s;
    assign d1      = seg_s - first_s;
    assign d3      = last_s - seg_s;

    assign jump_first = (nd2 > near_s) && (nd2 > d1);
    assign d2a        = jump_first ? d1 : d2;
    assign cur_a      = jump_first ? {1'b0, first_reg} : cur_seg_reg;
    assign pos_a      = jump_first ? '0 : cur_pos_reg;

    assign jump_last  = (d2a > near_s) && (d2a > d3);
    assign d2f        = jump_last ? -d3 : d2a;
    assign cur_f      = jump_last ? last_ext + SEG_W'(1) : cur_a;
    assign pos_f      = jump_last ? cap_reg : pos_a;
    assign fwd_f      = d2f > $signed(D_W'(0));

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        cur_seg_next   = cur_seg_reg;
        cur_pos_next   = cur_pos_reg;
        cap_next       = cap_reg;
        kind_next      = kind_reg;
        seg_in_next    = seg_in_reg;
        mask_next      = mask_reg;
        pos_next       = pos_reg;
        walk_seg_next  = walk_seg_reg;
        rem_next       = rem_reg;
        last_sz_next   = last_sz_reg;
        fwd_next       = fwd_reg;
        res_seg_next   = res_seg_reg;
        res_off_next   = res_off_reg;
        res_pos_next   = res_pos_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        rd_req_seg     = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST_SEG: first_next = cfg_data;
                REG_LAST_SEG:  last_next  = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next   = kind_t'(s_tuser);
                    seg_in_next = s_tdata[11:0];
                    mask_next   = s_tdata[43:12];
                    pos_next    = s_tdata[71:44];
                    state_next  = S_SETUP;
                end
            end

            S_SETUP:
            begin
                res_seg_next = '0;
                res_off_next = '0;
                res_pos_next = '0;
                unique case (kind_reg)
                    KIND_LOAD:
                    begin
                        state_next = S_LOAD;
                    end
                    KIND_POS2SEG:
                    begin
                        walk_seg_next = {1'b0, first_reg};
                        rem_next      = $signed(REM_W'(pos_reg));
                        last_sz_next  = '0;
                        mem_re        = 1'b1;
                        rd_req_seg    = {1'b0, first_reg};
                        state_next    = S_WALK;
                    end
                    KIND_CAPACITY:
                    begin
                        cur_seg_next = {1'b0, first_reg};
                        cur_pos_next = '0;
                        mem_re       = 1'b1;
                        rd_req_seg   = {1'b0, first_reg};
                        state_next   = S_WALK;
                    end
                    KIND_SEG2POS:
                    begin
                        priority if (seg_in_reg > last_reg)
                        begin
                            res_pos_next = cap_reg;
                            state_next   = S_RESULT;
                        end
                        else if (seg_in_reg < first_reg)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cur_seg_next = cur_f;
                            cur_pos_next = pos_f;
                            fwd_next     = fwd_f;
                            mem_re       = 1'b1;
                            rd_req_seg   = fwd_f ? cur_f : cur_f - SEG_W'(1);
                            state_next   = S_WALK;
                        end
                    end
                endcase
            end

            S_LOAD:
            begin
                // Drop loads to segments past the table.
                mem_we     = 32'(seg_in_reg) < 32'(MAX_SEGMENTS);
                state_next = S_RESULT;
            end

            S_WALK:
            begin
                unique case (kind_reg)
                    KIND_POS2SEG:
                    begin
                        if ((rem_reg > 0) && (walk_seg_reg <= last_ext))
                        begin
                            rem_next      = rem_reg - sz_s;
                            last_sz_next  = sz;
                            walk_seg_next = walk_seg_reg + SEG_W'(1);
                            mem_re        = 1'b1;
                            rd_req_seg    = walk_seg_reg + SEG_W'(1);
                        end
                        else
                        begin
                            // Walk ended: remainder used up, or ran off the end of tape with some left.
                            if (!rem_reg[REM_W-1])
                            begin
                                res_seg_next = walk_seg_reg;
                            end
                            else
                            begin
                                res_seg_next = walk_seg_reg - SEG_W'(1);
                                res_off_next = off_sum[OFF_W-1:0];
                            end
                            state_next = S_RESULT;
                        end
                    end
                    KIND_CAPACITY:
                    begin
                        if (cur_seg_reg <= last_ext)
                        begin
                            cur_pos_next = cur_pos_reg + POS_W'(sz);
                            cur_seg_next = cur_seg_reg + SEG_W'(1);
                            mem_re       = 1'b1;
                            rd_req_seg   = cur_seg_reg + SEG_W'(1);
                        end
                        else
                        begin
                            cap_next     = cur_pos_reg;
                            res_pos_next = cur_pos_reg;
                            state_next   = S_RESULT;
                        end
                    end
                    KIND_SEG2POS:
                    begin
                        if (fwd_reg && (cur_seg_reg < SEG_W'(seg_in_reg)))
                        begin
                            cur_pos_next = cur_pos_reg + POS_W'(sz);
                            cur_seg_next = cur_seg_reg + SEG_W'(1);
                            mem_re       = 1'b1;
                            rd_req_seg   = cur_seg_reg + SEG_W'(1);
                        end
                        else if (!fwd_reg && (cur_seg_reg > SEG_W'(seg_in_reg)))
                        begin
                            cur_pos_next = cur_pos_reg - POS_W'(sz);
                            cur_seg_next = cur_seg_reg - SEG_W'(1);
                            mem_re       = 1'b1;
                            rd_req_seg   = cur_seg_reg - SEG_W'(2);
                        end
                        else
                        begin
                            res_pos_next = cur_pos_reg;
                            state_next   = S_RESULT;
                        end
                    end
                    KIND_LOAD:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_RESULT:
            begin
                // Hold the result until the output register frees up.
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_pos_reg, res_off_reg, res_seg_reg};
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            cur_seg_reg   <= '0;
            cur_pos_reg   <= '0;
            cap_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            cur_seg_reg   <= cur_seg_next;
            cur_pos_reg   <= cur_pos_next;
            cap_reg       <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        seg_in_reg   <= seg_in_next;
        mask_reg     <= mask_next;
        pos_reg      <= pos_next;
        walk_seg_reg <= walk_seg_next;
        rem_reg      <= rem_next;
        last_sz_reg  <= last_sz_next;
        fwd_reg      <= fwd_next;
        res_seg_reg  <= res_seg_next;
        res_off_reg  <= res_off_next;
        res_pos_reg  <= res_pos_next;
    end

    // A segment query walk never overshoots its target.
    `ASSERT_IMPLIES(a_s2p_fwd_bound, clk, rst_n,
        (state_reg == S_WALK) && (kind_reg == KIND_SEG2POS) && fwd_reg,
        cur_seg_reg <= SEG_W'(seg_in_reg))
    `ASSERT_IMPLIES(a_s2p_bwd_bound, clk, rst_n,
        (state_reg == S_WALK) && (kind_reg == KIND_SEG2POS) && !fwd_reg,
        cur_seg_reg >= SEG_W'(seg_in_reg))
    // A position walk stops one past the last data segment at most.
    `ASSERT_IMPLIES(a_p2s_bound, clk, rst_n,
        (state_reg == S_WALK) && (kind_reg == KIND_POS2SEG),
        (walk_seg_reg <= last_ext + SEG_W'(1)) || (walk_seg_reg == {1'b0, first_reg}))
    // A finished result moves to the output register and frees the input side.
    `ASSERT_NEXT(a_result_issue, clk, rst_n,
        (state_reg == S_RESULT) && slot_free,
        out_valid_reg && (state_reg == S_IDLE))

endmodule

>>> design/tsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tsp_seg_size.sv
// Usable-size calculation for one segment from its bad-sector mask.
// Depends on tsp_pkg; popcount is registered, the size follows combinationally.
module tsp_seg_size #(
    parameter int SEGMENT_BYTES = tsp_pkg::DEF_SEGMENT_BYTES,
    parameter int SECTOR_BYTES  = tsp_pkg::DEF_SECTOR_BYTES
) (
    input  logic                                 clk,
    input  logic [tsp_pkg::MASK_W-1:0]           mask,
    output logic [$clog2(SEGMENT_BYTES+1)-1:0]   size
);
    import tsp_pkg::*;

    localparam int SIZE_W = $clog2(SEGMENT_BYTES + 1);
    localparam int CNT_W  = $clog2(MASK_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [31:0]      bad_bytes;
    logic [31:0]      good_bytes;

    assign cnt_next = CNT_W'($countones(mask));

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    // Floor at zero when bad sectors cover the whole segment.
    assign bad_bytes  = 32'(cnt_reg) * 32'(SECTOR_BYTES);
    assign good_bytes = 32'(SEGMENT_BYTES) - bad_bytes;
    assign size = (bad_bytes >= 32'(SEGMENT_BYTES)) ? '0 : good_bytes[SIZE_W-1:0];

endmodule
